/* rtl/dec_pkg.sv */
package dec_pkg;

  localparam int unsigned IN_W    = 216;
  localparam int unsigned OUT_W   = 88;
  localparam int unsigned VEL_W   = 20;
  localparam int unsigned LANES   = 4;
  localparam int unsigned Q_W     = 22;
  localparam int unsigned DIV_W   = 80;

  // pi as a Q2.28 fraction
  localparam logic [29:0] PI_Q28 = 30'd843314857;

  localparam logic signed [24:0] VEL_MAX = 25'sd524287;
  localparam logic signed [24:0] VEL_MIN = -25'sd524288;

  typedef struct packed {
    logic signed [23:0] first_pos_x;
    logic signed [23:0] first_pos_y;
    logic signed [19:0] first_vel_x;
    logic signed [19:0] first_vel_y;
    logic [15:0]        first_radius;
    logic               first_visible;
    logic signed [23:0] second_pos_x;
    logic signed [23:0] second_pos_y;
    logic signed [19:0] second_vel_x;
    logic signed [19:0] second_vel_y;
    logic [15:0]        second_radius;
    logic               second_visible;
  } in_item_t;

  // lanes: 0 first x, 1 first y, 2 second x, 3 second y
  typedef struct packed {
    logic [LANES-1:0][DIV_W-1:0] rem;
    logic [LANES-1:0][Q_W-1:0]   quo;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0]            sat;
    logic [DIV_W-1:0]            d2;
    logic [LANES-1:0][VEL_W-1:0] vel;
    logic                        hit;
  } div_item_t;

  typedef struct packed {
    logic [LANES-1:0][VEL_W-1:0] vel;
    logic                        collided;
  } res_item_t;

endpackage

/* rtl/dec_front.sv */
module dec_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  dec_pkg::in_item_t    up_item,
  output logic                 down_valid,
  input  logic                 down_ready,
  output dec_pkg::div_item_t   down_item
);

  localparam int unsigned NS = 9;

  logic [NS-1:0] v_r, v_nxt, en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || down_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign v_nxt      = {v_r[NS-2:0], up_valid};
  assign up_ready   = en[0];
  assign down_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  // stage 1: differences
  logic signed [24:0] dx1_r, dy1_r;
  logic signed [20:0] dvx1_r, dvy1_r;
  logic [16:0]        rs1_r;
  logic [15:0]        ra1_r, rb1_r;
  logic               vis1_r;
  logic [3:0][19:0]   vel1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx1_r  <= 25'(up_item.second_pos_x) - 25'(up_item.first_pos_x);
      dy1_r  <= 25'(up_item.second_pos_y) - 25'(up_item.first_pos_y);
      dvx1_r <= 21'(up_item.second_vel_x) - 21'(up_item.first_vel_x);
      dvy1_r <= 21'(up_item.second_vel_y) - 21'(up_item.first_vel_y);
      rs1_r  <= 17'(up_item.first_radius) + 17'(up_item.second_radius);
      ra1_r  <= up_item.first_radius;
      rb1_r  <= up_item.second_radius;
      vis1_r <= up_item.first_visible & up_item.second_visible;
      vel1_r <= {up_item.second_vel_y, up_item.second_vel_x,
                 up_item.first_vel_y, up_item.first_vel_x};
    end
  end

  // stage 2: squares and dot-product terms
  logic [47:0]        dxx2_r, dyy2_r;
  logic signed [45:0] sx2_r, sy2_r;
  logic [33:0]        rsq2_r;
  logic [31:0]        ra2_r, rb2_r;
  logic signed [17:0] dx2_r, dy2_r;
  logic               vis2_r;
  logic [3:0][19:0]   vel2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dxx2_r <= 48'(dx1_r * dx1_r);
      dyy2_r <= 48'(dy1_r * dy1_r);
      sx2_r  <= 46'(dvx1_r * dx1_r);
      sy2_r  <= 46'(dvy1_r * dy1_r);
      rsq2_r <= 34'(rs1_r * rs1_r);
      ra2_r  <= 32'(ra1_r * ra1_r);
      rb2_r  <= 32'(rb1_r * rb1_r);
      // a hit keeps the offsets inside 18 signed bits
      dx2_r  <= 18'(dx1_r);
      dy2_r  <= 18'(dy1_r);
      vis2_r <= vis1_r;
      vel2_r <= vel1_r;
    end
  end

  // stage 3: distance, dot product, area products
  logic [48:0]        dist3_r;
  logic signed [46:0] s3_r;
  logic [33:0]        rsq3_r;
  logic [61:0]        pa3_r, pb3_r;
  logic signed [17:0] dx3_r, dy3_r;
  logic               vis3_r;
  logic [3:0][19:0]   vel3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dist3_r <= 49'(dxx2_r) + 49'(dyy2_r);
      s3_r    <= 47'(sx2_r) + 47'(sy2_r);
      rsq3_r  <= rsq2_r;
      pa3_r   <= 62'(ra2_r * dec_pkg::PI_Q28);
      pb3_r   <= 62'(rb2_r * dec_pkg::PI_Q28);
      dx3_r   <= dx2_r;
      dy3_r   <= dy2_r;
      vis3_r  <= vis2_r;
      vel3_r  <= vel2_r;
    end
  end

  // stage 4: weights, hit test, magnitudes and signs
  logic [17:0] wa4, wb4;
  logic        eq4;
  assign wa4 = pa3_r[61:44];
  assign wb4 = pb3_r[61:44];
  assign eq4 = (wa4 == wb4);

  logic [34:0]      dist4_r;
  logic [18:0]      m1_4_r, m2_4_r, d4_r;
  logic [39:0]      sabs4_r;
  logic [16:0]      ax4_r, ay4_r;
  logic [3:0]       neg4_r;
  logic             hit4_r;
  logic [3:0][19:0] vel4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dist4_r <= dist3_r[34:0];
      hit4_r  <= vis3_r && (dist3_r <= 49'(rsq3_r)) && (dist3_r != '0);
      m1_4_r  <= eq4 ? 19'd1 : {wb4, 1'b0};
      m2_4_r  <= eq4 ? 19'd1 : {wa4, 1'b0};
      d4_r    <= eq4 ? 19'd1 : 19'(wa4) + 19'(wb4);
      sabs4_r <= 40'(s3_r[46] ? -s3_r : s3_r);
      ax4_r   <= 17'(dx3_r[17] ? -dx3_r : dx3_r);
      ay4_r   <= 17'(dy3_r[17] ? -dy3_r : dy3_r);
      // second disk takes the change with the opposite sign
      neg4_r  <= {~(dy3_r[17] ^ s3_r[46]), ~(dx3_r[17] ^ s3_r[46]),
                  dy3_r[17] ^ s3_r[46], dx3_r[17] ^ s3_r[46]};
      vel4_r  <= vel3_r;
    end
  end

  // stage 5: denominator and partial products of |a|*|s|
  logic [53:0]      den5_r;
  logic [1:0][36:0] pl5_r, ph5_r;
  logic [18:0]      m1_5_r, m2_5_r;
  logic [3:0]       neg5_r;
  logic             hit5_r;
  logic [3:0][19:0] vel5_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      den5_r   <= 54'(dist4_r * d4_r);
      pl5_r[0] <= 37'(ax4_r * sabs4_r[19:0]);
      ph5_r[0] <= 37'(ax4_r * sabs4_r[39:20]);
      pl5_r[1] <= 37'(ay4_r * sabs4_r[19:0]);
      ph5_r[1] <= 37'(ay4_r * sabs4_r[39:20]);
      m1_5_r   <= m1_4_r;
      m2_5_r   <= m2_4_r;
      neg5_r   <= neg4_r;
      hit5_r   <= hit4_r;
      vel5_r   <= vel4_r;
    end
  end

  // stage 6: assemble |a|*|s|
  logic [53:0]      den6_r;
  logic [1:0][56:0] p6_r;
  logic [18:0]      m1_6_r, m2_6_r;
  logic [3:0]       neg6_r;
  logic             hit6_r;
  logic [3:0][19:0] vel6_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int j = 0; j < 2; j++) begin
        p6_r[j] <= 57'(pl5_r[j]) + (57'(ph5_r[j]) << 20);
      end
      den6_r <= den5_r;
      m1_6_r <= m1_5_r;
      m2_6_r <= m2_5_r;
      neg6_r <= neg5_r;
      hit6_r <= hit5_r;
      vel6_r <= vel5_r;
    end
  end

  // stage 7: partial products with the mass factor
  logic [53:0]      den7_r;
  logic [3:0][47:0] lo7_r;
  logic [3:0][46:0] hi7_r;
  logic [3:0]       neg7_r;
  logic             hit7_r;
  logic [3:0][19:0] vel7_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int k = 0; k < 4; k++) begin
        lo7_r[k] <= 48'(p6_r[k%2][28:0] * ((k < 2) ? m1_6_r : m2_6_r));
        hi7_r[k] <= 47'(p6_r[k%2][56:29] * ((k < 2) ? m1_6_r : m2_6_r));
      end
      den7_r <= den6_r;
      neg7_r <= neg6_r;
      hit7_r <= hit6_r;
      vel7_r <= vel6_r;
    end
  end

  // stage 8: dividend 2N + den, divisor 2den (round half up)
  logic [3:0][79:0] x8_r;
  logic [79:0]      d2_8_r;
  logic [3:0]       neg8_r;
  logic             hit8_r;
  logic [3:0][19:0] vel8_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int k = 0; k < 4; k++) begin
        x8_r[k] <= ((80'(lo7_r[k]) + (80'(hi7_r[k]) << 29)) << 1) + 80'(den7_r);
      end
      d2_8_r <= 80'(den7_r) << 1;
      neg8_r <= neg7_r;
      hit8_r <= hit7_r;
      vel8_r <= vel7_r;
    end
  end

  // stage 9: flag quotients too large for the divider
  dec_pkg::div_item_t item9_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int k = 0; k < 4; k++) begin
        item9_r.rem[k] <= x8_r[k];
        item9_r.sat[k] <= x8_r[k] >= (d2_8_r << dec_pkg::Q_W);
      end
      item9_r.quo <= '0;
      item9_r.neg <= neg8_r;
      item9_r.d2  <= d2_8_r;
      item9_r.vel <= vel8_r;
      item9_r.hit <= hit8_r;
    end
  end

  assign down_item = item9_r;

endmodule

/* rtl/dec_div.sv */
module dec_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  dec_pkg::div_item_t up_item,
  output logic               down_valid,
  input  logic               down_ready,
  output dec_pkg::div_item_t down_item
);

  localparam int unsigned NS = dec_pkg::Q_W;

  function automatic dec_pkg::div_item_t div_step(input dec_pkg::div_item_t it,
                                                   input int unsigned sh);
    dec_pkg::div_item_t         o;
    logic [dec_pkg::DIV_W:0]    trial;
    o = it;
    for (int l = 0; l < dec_pkg::LANES; l++) begin
      trial = {1'b0, it.rem[l]} - {1'b0, it.d2 << sh};
      if (!trial[dec_pkg::DIV_W]) begin
        o.rem[l] = trial[dec_pkg::DIV_W-1:0];
      end
      o.quo[l] = {it.quo[l][dec_pkg::Q_W-2:0], !trial[dec_pkg::DIV_W]};
    end
    return o;
  endfunction

  logic [NS-1:0]      v_r, v_nxt, en;
  dec_pkg::div_item_t stage_r [NS];
  dec_pkg::div_item_t src [NS];

  always_comb begin
    en[NS-1] = !v_r[NS-1] || down_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign v_nxt  = {v_r[NS-2:0], up_valid};
  assign src[0] = up_item;

  for (genvar j = 1; j < NS; j++) begin : g_src
    assign src[j] = stage_r[j-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  // one quotient bit per stage, most significant first
  always_ff @(posedge clk) begin
    for (int j = 0; j < NS; j++) begin
      if (en[j]) begin
        stage_r[j] <= div_step(src[j], NS - 1 - j);
      end
    end
  end

  assign up_ready   = en[0];
  assign down_valid = v_r[NS-1];
  assign down_item  = stage_r[NS-1];

endmodule

/* rtl/dec_out.sv */
module dec_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  dec_pkg::div_item_t up_item,
  output logic               down_valid,
  input  logic               down_ready,
  output dec_pkg::res_item_t down_item
);

  logic               out_valid_r;
  dec_pkg::res_item_t res_r, res_nxt;

  always_comb begin
    logic [dec_pkg::Q_W-1:0] mag;
    logic signed [23:0]      delta;
    logic signed [24:0]      sum;
    for (int k = 0; k < dec_pkg::LANES; k++) begin
      mag   = up_item.sat[k] ? '1 : up_item.quo[k];
      delta = up_item.neg[k] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      sum   = 25'(signed'(up_item.vel[k])) + 25'(delta);
      if (!up_item.hit) begin
        res_nxt.vel[k] = up_item.vel[k];
      end else if (sum > dec_pkg::VEL_MAX) begin
        res_nxt.vel[k] = dec_pkg::VEL_MAX[dec_pkg::VEL_W-1:0];
      end else if (sum < dec_pkg::VEL_MIN) begin
        res_nxt.vel[k] = dec_pkg::VEL_MIN[dec_pkg::VEL_W-1:0];
      end else begin
        res_nxt.vel[k] = sum[dec_pkg::VEL_W-1:0];
      end
    end
    res_nxt.collided = up_item.hit;
  end

  assign up_ready = !out_valid_r || down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      res_r <= res_nxt;
    end
  end

  assign down_valid = out_valid_r;
  assign down_item  = res_r;

endmodule

/* rtl/disk_elastic_collision.sv */
// Elastic collision of two disks: one request per clock goes in, one result per
// clock comes out while the output is not stalled. Nine arithmetic stages form
// the offsets, the squared distance, the dot product, the area weights and the
// scaled numerators; a 22-stage restoring divider then yields one quotient bit
// per stage for all four velocity lanes together, and a final registered stage
// applies the change and saturates. Back-pressure stalls each stage only when
// the one after it is full, so bubbles close up and nothing is lost.
module disk_elastic_collision (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
  // first_visible, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
  // second_radius, second_visible, zero pad
  input  logic [215:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
  // collided, zero pad
  output logic [87:0]  out_tdata
);

  dec_pkg::in_item_t  in_item;
  dec_pkg::div_item_t front_item, div_item;
  dec_pkg::res_item_t res_item;
  logic               front_valid, front_ready, div_valid, div_ready;

  assign in_item.first_pos_x    = in_tdata[23:0];
  assign in_item.first_pos_y    = in_tdata[47:24];
  assign in_item.first_vel_x    = in_tdata[67:48];
  assign in_item.first_vel_y    = in_tdata[87:68];
  assign in_item.first_radius   = in_tdata[103:88];
  assign in_item.first_visible  = in_tdata[104];
  assign in_item.second_pos_x   = in_tdata[128:105];
  assign in_item.second_pos_y   = in_tdata[152:129];
  assign in_item.second_vel_x   = in_tdata[172:153];
  assign in_item.second_vel_y   = in_tdata[192:173];
  assign in_item.second_radius  = in_tdata[208:193];
  assign in_item.second_visible = in_tdata[209];

  dec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .up_item    (in_item),
    .down_valid (front_valid),
    .down_ready (front_ready),
    .down_item  (front_item)
  );

  dec_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (front_valid),
    .up_ready   (front_ready),
    .up_item    (front_item),
    .down_valid (div_valid),
    .down_ready (div_ready),
    .down_item  (div_item)
  );

  dec_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (div_valid),
    .up_ready   (div_ready),
    .up_item    (div_item),
    .down_valid (out_tvalid),
    .down_ready (out_tready),
    .down_item  (res_item)
  );

  assign out_tdata = {7'b0000000, res_item.collided, res_item.vel[3], res_item.vel[2],
                      res_item.vel[1], res_item.vel[0]};

endmodule

/* rtl/dec_checker.sv */
module dec_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [87:0]  out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result changed");

  // input may only stall when the pipe is backed up from the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output free");

endmodule

bind disk_elastic_collision dec_checker u_dec_checker (.*);
